// ===== design/rpar_pkg.sv =====
// types and constants shared by the response packet ack/retry checker
// no dependencies; imported by every module of the block
`default_nettype none

package rpar_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_ACK_CODE    = 2'd0;
  localparam logic [1:0] REG_NACK_CODE   = 2'd1;
  localparam logic [1:0] REG_RETRY_LIMIT = 2'd2;

  localparam logic [7:0] ACK_CODE_RESET    = 8'h00;
  localparam logic [7:0] NACK_CODE_RESET   = 8'hff;
  localparam logic [3:0] RETRY_LIMIT_RESET = 4'd3;

  // echoed error codes in byte 2
  localparam logic [7:0] CODE_CHECKSUM = 8'h00;
  localparam logic [7:0] CODE_SIZE     = 8'h01;
  localparam logic [7:0] CODE_DEVINFO  = 8'h02;
  localparam logic [7:0] CODE_MISMATCH = 8'h03;
  localparam logic [7:0] CODE_TIMEOUT  = 8'h04;

  localparam logic [7:0] MIN_LENGTH = 8'd3;
  localparam logic [7:0] POS_MAX    = 8'hff;

  // outcome codes
  localparam logic [2:0] OUT_OK       = 3'd0;
  localparam logic [2:0] OUT_RESEND   = 3'd1;
  localparam logic [2:0] OUT_CHECKSUM = 3'd2;
  localparam logic [2:0] OUT_SIZE     = 3'd3;
  localparam logic [2:0] OUT_TIMEOUT  = 3'd4;
  localparam logic [2:0] OUT_DEVINFO  = 3'd5;
  localparam logic [2:0] OUT_MISMATCH = 3'd6;
  localparam logic [2:0] OUT_COMM_ERR = 3'd7;

  typedef struct packed {
    logic [7:0] ack_code;
    logic [7:0] nack_code;
    logic [3:0] retry_limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
    logic [7:0] sent_command;
  } item_t;

  typedef struct packed {
    logic [2:0] outcome;
    logic [3:0] attempt;
  } result_t;

endpackage

`default_nettype wire

// ===== design/rpar_cfg.sv =====
// configuration register file: ack code, nack code, retry limit
// depends on rpar_pkg
`default_nettype none

module rpar_cfg (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  output rpar_pkg::cfg_t   cfg
);
  import rpar_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ack_code    <= ACK_CODE_RESET;
      cfg.nack_code   <= NACK_CODE_RESET;
      cfg.retry_limit <= RETRY_LIMIT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ACK_CODE:    cfg.ack_code    <= cfg_data;
        REG_NACK_CODE:   cfg.nack_code   <= cfg_data;
        REG_RETRY_LIMIT: cfg.retry_limit <= cfg_data[3:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/rpar_in_stage.sv =====
// input register stage holding one accepted request
// depends on rpar_pkg
`default_nettype none

module rpar_in_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire rpar_pkg::item_t  in_item,
  output logic                  item_valid,
  output rpar_pkg::item_t       item,
  input  wire logic             item_take
);
  import rpar_pkg::*;

  // stage may load when empty or when its content moves on this cycle
  assign in_ready = !item_valid || item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== design/rpar_core.sv =====
// packet parse state, running checksum, attempt counter and outcome decode
// depends on rpar_pkg
`default_nettype none

module rpar_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire rpar_pkg::cfg_t   cfg,
  input  wire logic             item_valid,
  input  wire rpar_pkg::item_t  item,
  input  wire logic             item_take,
  output logic                  res_valid,
  output rpar_pkg::result_t     res
);
  import rpar_pkg::*;

  logic [7:0] byte_position;
  logic [7:0] packet_length;
  logic [7:0] packet_type;
  logic [7:0] code_byte;
  logic [7:0] running_sum;
  logic       checksum_good;
  logic [3:0] attempt_count;

  logic [7:0] byte_position_next;
  logic [7:0] packet_length_next;
  logic [7:0] packet_type_next;
  logic [7:0] code_byte_next;
  logic [7:0] running_sum_next;
  logic       checksum_good_next;
  logic [3:0] attempt_count_next;

  logic [7:0] chk_pos;
  logic [4:0] att_inc;
  logic       final_outcome;
  logic [2:0] outcome;

  assign chk_pos = packet_length - 8'd1;
  assign att_inc = {1'b0, attempt_count} + 5'd1;

  // field capture and checksum
  always_comb begin
    packet_length_next = packet_length;
    packet_type_next   = packet_type;
    code_byte_next     = code_byte;
    running_sum_next   = running_sum;
    checksum_good_next = checksum_good;
    if (byte_position == 8'd0) begin
      packet_length_next = item.rx_byte;
      packet_type_next   = 8'd0;
      code_byte_next     = 8'd0;
      running_sum_next   = item.rx_byte;
      checksum_good_next = 1'b0;
    end else begin
      if (byte_position == 8'd1) begin
        packet_type_next = item.rx_byte;
      end else if (byte_position == 8'd2) begin
        code_byte_next = item.rx_byte;
      end
      if (packet_length >= MIN_LENGTH) begin
        if (byte_position < chk_pos) begin
          running_sum_next = running_sum + item.rx_byte;
        end else if (byte_position == chk_pos) begin
          checksum_good_next = ((8'd0 - running_sum) == item.rx_byte);
        end
      end
    end
  end

  // outcome decode on the last byte
  always_comb begin
    final_outcome = 1'b1;
    if (packet_type_next != cfg.ack_code && packet_type_next != cfg.nack_code) begin
      outcome = OUT_COMM_ERR;
    end else if (packet_type_next == cfg.ack_code && code_byte_next == item.sent_command
                 && checksum_good_next) begin
      outcome = OUT_OK;
    end else if (code_byte_next inside {CODE_CHECKSUM, CODE_SIZE, CODE_TIMEOUT}) begin
      if (att_inc >= {1'b0, cfg.retry_limit}) begin
        case (code_byte_next)
          CODE_CHECKSUM: outcome = OUT_CHECKSUM;
          CODE_SIZE:     outcome = OUT_SIZE;
          default:       outcome = OUT_TIMEOUT;
        endcase
      end else begin
        outcome       = OUT_RESEND;
        final_outcome = 1'b0;
      end
    end else if (code_byte_next == CODE_DEVINFO) begin
      outcome = OUT_DEVINFO;
    end else if (code_byte_next == CODE_MISMATCH) begin
      outcome = OUT_MISMATCH;
    end else begin
      outcome = OUT_COMM_ERR;
    end
  end

  always_comb begin
    if (item.last_byte) begin
      byte_position_next = 8'd0;
      attempt_count_next = final_outcome ? 4'd0 : att_inc[3:0];
    end else begin
      byte_position_next = (byte_position < POS_MAX) ? byte_position + 8'd1 : byte_position;
      attempt_count_next = attempt_count;
    end
  end

  assign res_valid   = item_valid && item.last_byte;
  assign res.outcome = outcome;
  assign res.attempt = attempt_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 8'd0;
      packet_length <= 8'd0;
      packet_type   <= 8'd0;
      code_byte     <= 8'd0;
      running_sum   <= 8'd0;
      checksum_good <= 1'b0;
      attempt_count <= 4'd0;
    end else if (item_take) begin
      byte_position <= byte_position_next;
      packet_length <= packet_length_next;
      packet_type   <= packet_type_next;
      code_byte     <= code_byte_next;
      running_sum   <= running_sum_next;
      checksum_good <= checksum_good_next;
      attempt_count <= attempt_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/rpar_out_stage.sv =====
// result register toward the downstream stream
// depends on rpar_pkg
`default_nettype none

module rpar_out_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               res_load,
  input  wire rpar_pkg::result_t  res,
  output logic                    res_space,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output rpar_pkg::result_t       out_res
);
  import rpar_pkg::*;

  assign res_space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_space) begin
      out_valid <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (res_space && res_load) begin
      out_res <= res;
    end
  end

endmodule

`default_nettype wire

// ===== design/response_packet_ack_retry_checker.sv =====
// top level of the response packet ack/retry checker
// depends on rpar_pkg, rpar_cfg, rpar_in_stage, rpar_core, rpar_out_stage
//
// usage:
//   s_* carries the response bytes one request per byte, in packet order;
//   s_tlast marks the last byte of a response. sent_command is sampled
//   with the last byte only. m_* carries one result per response, given
//   on its last byte: outcome (ok, resend, or a final error) and the
//   attempt number that the response answered.
//   cfg_* writes ack_code (index 0), nack_code (1) and retry_limit (2);
//   other indexes are dropped. cfg_ready is always high. write only while
//   the block is idle.
// path: a byte is held in the input register, where checksum, field
//   capture and outcome decode run; its result is registered in the
//   output register that drives m_*.
// throughput: one byte per cycle, set by the 8-bit sum and compares in the
//   core, while no last byte waits for room in the output register.
// reset: rst (synchronous) clears the parse state and attempt counter and
//   restores the register defaults; the stream starts at byte 0.
// stall: when m_tready is low with a result pending, non-last bytes still
//   flow; a last byte waits in the input register and s_tready drops.
`default_nettype none

module response_packet_ack_retry_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  // response byte stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [7:0] rx_byte, [15:8] sent_command
  input  wire logic        s_tlast,   // last_byte
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata,   // [2:0] outcome, [6:3] attempt, [7] zero
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);
  import rpar_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  item_t   item;
  result_t res;
  result_t out_res;
  logic    item_valid;
  logic    item_take;
  logic    res_valid;
  logic    res_space;

  assign cfg_ready = 1'b1;

  assign in_item.rx_byte      = s_tdata[7:0];
  assign in_item.sent_command = s_tdata[15:8];
  assign in_item.last_byte    = s_tlast;

  // a byte leaves the input register unless it carries a result with
  // no room in the output register
  assign item_take = item_valid && (!item.last_byte || res_space);

  rpar_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rpar_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  rpar_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res_valid  (res_valid),
    .res        (res)
  );

  rpar_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_load  (res_valid),
    .res       (res),
    .res_space (res_space),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {1'b0, out_res.attempt, out_res.outcome};

endmodule

`default_nettype wire
